// File: design/midi_clock_tempo_meter_core_macros.svh
// Assertion macros for the tempo meter core.
`ifndef MIDI_CLOCK_TEMPO_METER_CORE_MACROS_SVH
`define MIDI_CLOCK_TEMPO_METER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MCTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tempo meter assertion failed");
`define MCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tempo meter assertion failed");
`else
`define MCTM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MCTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/mctm_pkg.sv
`timescale 1ns / 1ps

package mctm_pkg;

    localparam int BLOCK_SIZE = 24;

    localparam int STAMP_W  = 32;
    localparam int HZ_W     = 30;
    localparam int TEMPO_W  = 28;
    localparam int SUM_W    = STAMP_W + $clog2(BLOCK_SIZE);
    localparam int TALLY_W  = $clog2(BLOCK_SIZE + 1);
    localparam int US_W     = 20;
    // widest dividend: ticks times one million
    localparam int QW       = STAMP_W + US_W;
    localparam int REM_W    = STAMP_W + 1;
    localparam int CNT_W    = $clog2(QW + 1);
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 96;
    localparam int M_USER_W = 1;

    localparam logic [US_W-1:0]    US_PER_S    = US_W'(1000000);
    localparam logic [TEMPO_W-1:0] TEMPO_NUM   =
        TEMPO_W'((64'd60 * 64'd1000000 * 64'd100) / 64'd24);
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(12000);
    localparam logic [HZ_W-1:0]    HZ_RESET    = HZ_W'(1000000);

    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_UPWARD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_HZ    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_MUL_GAP,
        S_CHECK,
        S_DIV,
        S_MUL_AVG,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_AVG,
        DIV_US,
        DIV_TEMPO
    } div_kind_t;

endpackage

// File: design/midi_clock_tempo_meter_core.sv
`timescale 1ns / 1ps
`include "midi_clock_tempo_meter_core_macros.svh"
// MIDI clock tempo meter.
// s_axis carries one counter timestamp per MIDI clock pulse; m_axis returns one
// result per pulse: tempo in BPM x100 and the last interval and the timestamp in
// tdata, the tempo-valid flag in tuser. The cfg channel sets the counter
// direction (index 0) and the counter frequency in Hz (index 1); the user is
// to write it only while idle; the block does not enforce it. A pulse that
// does not close an averaging block goes through the gap, multiply and check
// states to done; a first pulse or a zero interval goes from gap to done. A
// pulse that closes a block passes through one shared restoring divider three
// times, one quotient bit a cycle: the block average (37 steps), ticks to
// microseconds (52 steps) and the tempo (28 steps). One pulse is in work at a
// time; s_axis_tready is high only while the sequencer is idle, so the next
// pulse is taken in the cycle after the result is loaded. The result sits in
// an output register, so the next pulse is taken while it waits; if the receiver
// stalls, the following result holds in the sequencer until the register frees.
// Reset (aresetn low, synchronous) clears all measurement state, sets the tempo
// to 120.00 BPM (not yet valid), a down-counting counter at 1 MHz.
module midi_clock_tempo_meter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mctm_pkg::S_DATA_W-1:0] s_axis_tdata,   // [31:0] pulse_time
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [27:0] tempo_x100, [59:28] interval_count, [91:60] stamp_seen, [95:92] zero
    output logic [mctm_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic [mctm_pkg::M_USER_W-1:0] m_axis_tuser,   // [0] tempo_valid
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mctm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mctm_pkg::HZ_W-1:0]      cfg_data
);
    import mctm_pkg::*;

    state_t                state_reg, state_next;
    logic [STAMP_W-1:0]    stamp_reg, stamp_next;
    logic [STAMP_W-1:0]    prev_reg, prev_next;
    logic [STAMP_W-1:0]    gap_reg, gap_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [TALLY_W-1:0]    tally_reg, tally_next;
    logic [TEMPO_W-1:0]    tempo_reg, tempo_next;
    logic                  valid_flag_reg, valid_flag_next;
    logic                  counts_up_reg, counts_up_next;
    logic [HZ_W-1:0]       hz_reg, hz_next;
    logic [STAMP_W-1:0]    op_reg, op_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [STAMP_W-1:0]    den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    div_kind_t             kind_reg, kind_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;
    logic [M_USER_W-1:0]   m_user_reg, m_user_next;

    logic [STAMP_W-1:0]    gap_raw;
    logic [HZ_W-1:0]       hz_eff;
    logic [QW-1:0]         mul_prod;
    logic [REM_W-1:0]      rem_sh;
    logic                  div_ge;
    logic [QW-1:0]         q_step;
    logic [STAMP_W-1:0]    us_val;
    logic [TALLY_W-1:0]    tally_inc;
    logic [SUM_W-1:0]      sum_add;
    logic [TEMPO_W-1:0]    tempo_out;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign gap_raw   = counts_up_reg ? (stamp_reg - prev_reg) : (prev_reg - stamp_reg);
    assign hz_eff    = (hz_reg == '0) ? HZ_W'(1) : hz_reg;
    // the one multiplier, shared by the interval check and the average conversion
    assign mul_prod  = QW'(op_reg) * QW'(US_PER_S);
    assign tally_inc = tally_reg + TALLY_W'(1);
    assign sum_add   = sum_reg + SUM_W'(gap_reg);
    assign tempo_out = valid_flag_reg ? tempo_reg : '0;

    // one restoring divider step
    assign rem_sh = {rem_reg[REM_W-2:0], q_reg[QW-1]};
    assign div_ge = (rem_sh >= {1'b0, den_reg});
    assign q_step = {q_reg[QW-2:0], div_ge};

    // microseconds: saturate, and never zero
    always_comb begin
        if (|q_step[QW-1:STAMP_W]) begin
            us_val = '1;
        end else if (q_step[STAMP_W-1:0] == '0) begin
            us_val = STAMP_W'(1);
        end else begin
            us_val = q_step[STAMP_W-1:0];
        end
    end

    always_comb begin
        state_next      = state_reg;
        stamp_next      = stamp_reg;
        prev_next       = prev_reg;
        gap_next        = gap_reg;
        sum_next        = sum_reg;
        tally_next      = tally_reg;
        tempo_next      = tempo_reg;
        valid_flag_next = valid_flag_reg;
        counts_up_next  = counts_up_reg;
        hz_next         = hz_reg;
        op_next         = op_reg;
        q_next          = q_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        cnt_next        = cnt_reg;
        kind_next       = kind_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                REG_COUNTS_UPWARD: counts_up_next = cfg_data[0];
                REG_COUNTER_HZ:    hz_next        = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    stamp_next = s_axis_tdata;
                    state_next = S_GAP;
                end
            end
            S_GAP: begin
                prev_next = stamp_reg;
                if (prev_reg == '0 || gap_raw == '0) begin
                    state_next = S_DONE;
                end else begin
                    gap_next   = gap_raw;
                    op_next    = gap_raw;
                    state_next = S_MUL_GAP;
                end
            end
            S_MUL_GAP: begin
                q_next     = mul_prod;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // below one microsecond: the interval is dropped
                if (q_reg < QW'(hz_eff)) begin
                    state_next = S_DONE;
                end else if (tally_inc >= TALLY_W'(BLOCK_SIZE)) begin
                    sum_next   = '0;
                    tally_next = '0;
                    q_next     = QW'(sum_add) << (QW - SUM_W);
                    rem_next   = '0;
                    den_next   = STAMP_W'(BLOCK_SIZE);
                    cnt_next   = CNT_W'(SUM_W);
                    kind_next  = DIV_AVG;
                    state_next = S_DIV;
                end else begin
                    sum_next   = sum_add;
                    tally_next = tally_inc;
                    state_next = S_DONE;
                end
            end
            S_DIV: begin
                q_next   = q_step;
                rem_next = div_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    case (kind_reg)
                        DIV_AVG: begin
                            op_next    = q_step[STAMP_W-1:0];
                            state_next = S_MUL_AVG;
                        end
                        DIV_US: begin
                            q_next     = QW'(TEMPO_NUM) << (QW - TEMPO_W);
                            rem_next   = '0;
                            den_next   = us_val;
                            cnt_next   = CNT_W'(TEMPO_W);
                            kind_next  = DIV_TEMPO;
                        end
                        DIV_TEMPO: begin
                            tempo_next      = q_step[TEMPO_W-1:0];
                            valid_flag_next = 1'b1;
                            state_next      = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_MUL_AVG: begin
                q_next     = mul_prod;
                rem_next   = '0;
                den_next   = STAMP_W'(hz_eff);
                cnt_next   = CNT_W'(QW);
                kind_next  = DIV_US;
                state_next = S_DIV;
            end
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(M_DATA_W - TEMPO_W - 2 * STAMP_W)'(0),
                                    stamp_reg, gap_reg, tempo_out};
                    m_user_next  = valid_flag_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            prev_reg       <= '0;
            gap_reg        <= '0;
            sum_reg        <= '0;
            tally_reg      <= '0;
            tempo_reg      <= TEMPO_RESET;
            valid_flag_reg <= 1'b0;
            counts_up_reg  <= 1'b0;
            hz_reg         <= HZ_RESET;
            m_valid_reg    <= 1'b0;
            stamp_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            prev_reg       <= prev_next;
            gap_reg        <= gap_next;
            sum_reg        <= sum_next;
            tally_reg      <= tally_next;
            tempo_reg      <= tempo_next;
            valid_flag_reg <= valid_flag_next;
            counts_up_reg  <= counts_up_next;
            hz_reg         <= hz_next;
            m_valid_reg    <= m_valid_next;
            stamp_reg      <= stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        cnt_reg    <= cnt_next;
        kind_reg   <= kind_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    `MCTM_ASSERT_IMPL(a_tally_below_block, aclk, aresetn, 1'b1,
        tally_reg < TALLY_W'(BLOCK_SIZE))
    `MCTM_ASSERT_NEXT(a_valid_sticky, aclk, aresetn, valid_flag_reg, valid_flag_reg)
    `MCTM_ASSERT_IMPL(a_rem_below_den, aclk, aresetn, state_reg == S_DIV,
        rem_reg < {1'b0, den_reg})
    `MCTM_ASSERT_NEXT(a_gap_nonzero, aclk, aresetn, state_reg == S_MUL_GAP, gap_reg != '0)

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import mctm_pkg::*;

    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned PULSE_GOAL   = 1650;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned TAIL_CYCLES  = 130;
    // 60 s * 1e6 us * 100 / 24 pulses per beat
    localparam longint unsigned BEAT_NUMERATOR = (64'd60 * 64'd1000000 * 64'd100) / 64'd24;

    typedef struct {
        logic [TEMPO_W-1:0] tempo_x100;
        logic               tempo_valid;
        logic [STAMP_W-1:0] interval_count;
        logic [STAMP_W-1:0] stamp_seen;
    } beat_report_t;

    class tempo_tracker;
        logic               upward;
        logic [HZ_W-1:0]    count_hz;
        logic [STAMP_W-1:0] last_stamp;
        logic [STAMP_W-1:0] latest_gap;
        logic [STAMP_W-1:0] echoed;
        logic [SUM_W-1:0]   tick_total;
        int unsigned        gaps_in_block;
        logic [TEMPO_W-1:0] bpm_x100;
        logic               tempo_known;
        beat_report_t       due[$];
        int unsigned        errors;

        function new();
            upward        = 1'b0;
            count_hz      = 30'd1000000;
            last_stamp    = '0;
            latest_gap    = '0;
            echoed        = '0;
            tick_total    = '0;
            gaps_in_block = 0;
            bpm_x100      = 28'd12000;
            tempo_known   = 1'b0;
            errors        = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task report_error(input string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HZ_W-1:0] value);
            if (idx == REG_COUNTS_UPWARD)
                upward = value[0];
            else if (idx == REG_COUNTER_HZ)
                count_hz = value;
        endfunction

        // a zero frequency counts as 1 Hz; results above 32 bits saturate
        function logic [STAMP_W-1:0] ticks_to_micros(input logic [STAMP_W-1:0] ticks);
            longint unsigned q;
            q = (64'(ticks) * 64'd1000000) / ((count_hz == 0) ? 64'd1 : 64'(count_hz));
            return (q > 64'hFFFF_FFFF) ? '1 : STAMP_W'(q);
        endfunction

        function void note_pulse(input logic [STAMP_W-1:0] now);
            logic [STAMP_W-1:0] gap;
            logic [STAMP_W-1:0] us;
            beat_report_t want;
            echoed = now;
            if (last_stamp == 0) begin
                // nothing to measure against yet
                last_stamp = now;
            end else begin
                gap = upward ? now - last_stamp : last_stamp - now;
                last_stamp = now;
                if (gap != 0) begin
                    latest_gap = gap;
                    if (ticks_to_micros(gap) != 0) begin
                        tick_total += gap;
                        gaps_in_block++;
                        if (gaps_in_block >= BLOCK_SIZE) begin
                            us = ticks_to_micros(STAMP_W'(tick_total / BLOCK_SIZE));
                            if (us == 0)
                                us = 1;
                            bpm_x100      = TEMPO_W'(BEAT_NUMERATOR / us);
                            tempo_known   = 1'b1;
                            tick_total    = '0;
                            gaps_in_block = 0;
                        end
                    end
                end
            end
            want.tempo_x100     = tempo_known ? bpm_x100 : '0;
            want.tempo_valid    = tempo_known;
            want.interval_count = latest_gap;
            want.stamp_seen     = echoed;
            due.push_back(want);
        endfunction

        task check_report(input beat_report_t got);
            beat_report_t want;
            if (due.size() == 0) begin
                report_error($sformatf("result with none pending, stamp %h", got.stamp_seen));
                return;
            end
            want = due.pop_front();
            if (got.tempo_x100 !== want.tempo_x100)
                report_error($sformatf("stamp %h: tempo_x100 %0d, want %0d",
                                       want.stamp_seen, got.tempo_x100, want.tempo_x100));
            if (got.tempo_valid !== want.tempo_valid)
                report_error($sformatf("stamp %h: tempo_valid %b, want %b",
                                       want.stamp_seen, got.tempo_valid, want.tempo_valid));
            if (got.interval_count !== want.interval_count)
                report_error($sformatf("stamp %h: interval_count %h, want %h",
                                       want.stamp_seen, got.interval_count,
                                       want.interval_count));
            if (got.stamp_seen !== want.stamp_seen)
                report_error($sformatf("stamp_seen %h, want %h",
                                       got.stamp_seen, want.stamp_seen));
        endtask
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [M_USER_W-1:0]   m_axis_tuser;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [HZ_W-1:0]       cfg_data      = '0;

    tempo_tracker    tracker     = new();
    int unsigned     burst_left  = 0;
    int unsigned     pulses_sent = 0;
    int unsigned     rx_left     = 0;
    int unsigned     quiet       = 0;
    logic            cur_up      = 1'b0;
    logic [HZ_W-1:0] cur_hz      = 30'd1000000;

    midi_clock_tempo_meter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 aclk = ~aclk;

    // valid stays up within a burst; gaps go in between bursts
    task automatic send_pulse(input logic [STAMP_W-1:0] stamp);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pulses_sent++;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 160)
                                                : $urandom_range(1, 8))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_counter(input logic wr_dir, input logic up,
                               input logic wr_hz, input logic [HZ_W-1:0] hz);
        if (wr_dir) begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_COUNTS_UPWARD;
            cfg_data  <= HZ_W'(up);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cur_up = up;
        end
        if (wr_hz) begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_COUNTER_HZ;
            cfg_data  <= hz;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cur_hz = hz;
        end
        cfg_valid <= 1'b0;
    endtask

    // steady pulse train in the current direction, with flaws mixed in at 1 in flaw_odds
    task automatic play_run(input int unsigned count, input int unsigned flaw_odds,
                            input logic [STAMP_W-1:0] lo, input logic [STAMP_W-1:0] hi);
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] stride;
        stamp = $urandom;
        repeat (count) begin
            stride = $urandom_range(hi, lo);
            stamp  = cur_up ? stamp + stride : stamp - stride;
            if (flaw_odds != 0 && $urandom_range(1, flaw_odds) == 1) begin
                case ($urandom_range(0, 4))
                    0: send_pulse('0);
                    1: send_pulse(stamp);
                    2: send_pulse($urandom);
                    3: send_pulse(cur_up ? stamp - 1 : stamp + 1);
                    default: send_pulse(cur_up ? stamp + 1 : stamp - 1);
                endcase
            end
            send_pulse(stamp);
        end
    endtask

    // receiver: long ready stretches, hard stalls and choppy spells
    always @(posedge aclk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_axis_tready <= 1'b0;
                    rx_left       <= $urandom_range(1, 30);
                end
                1: begin
                    m_axis_tready <= 1'b1;
                    rx_left       <= $urandom_range(50, 400);
                end
                default: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                    rx_left       <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    always @(posedge aclk) begin : watch
        beat_report_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.apply_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                tracker.note_pulse(s_axis_tdata[STAMP_W-1:0]);
            if (m_axis_tvalid && m_axis_tready) begin
                got.tempo_x100     = m_axis_tdata[TEMPO_W-1:0];
                got.interval_count = m_axis_tdata[TEMPO_W +: STAMP_W];
                got.stamp_seen     = m_axis_tdata[TEMPO_W + STAMP_W +: STAMP_W];
                got.tempo_valid    = m_axis_tuser[0];
                tracker.check_report(got);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : main
        logic [HZ_W-1:0]    hz;
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] hi;
        longint unsigned    nominal;
        longint unsigned    bpm;
        int unsigned        pick;
        int unsigned        shift;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // down-counting at 1 MHz out of reset
        send_pulse(32'd0);              // stamp of zero leaves no previous pulse
        send_pulse(32'd5000);           // so this is a first pulse again
        send_pulse(32'd5000);           // zero interval
        send_pulse(32'd3000);
        send_pulse(32'hFFFF_F000);      // wraps through zero
        send_pulse(32'hFFFF_FFFF);
        wait_results();
        set_counter(1'b1, 1'b1, 1'b1, '1);
        send_pulse(32'd100);
        send_pulse(32'd600);            // under a microsecond at the fastest counter
        send_pulse(32'd2600);
        send_pulse(32'h8000_0000);
        send_pulse(32'd0);
        wait_results();
        set_counter(1'b0, 1'b0, 1'b1, '0);    // zero frequency taken as 1 Hz
        send_pulse(32'd10);
        send_pulse(32'd4305);           // microseconds saturate
        send_pulse(32'hFFFF_FFFF);
        wait_results();
        set_counter(1'b1, 1'b0, 1'b1, 30'd1000000000);
        send_pulse(32'h8000_0000);
        send_pulse(32'h7FFF_FC18);      // exactly one microsecond

        while (pulses_sent < PULSE_GOAL) begin
            wait_results();
            pick = $urandom_range(0, 9);
            if (pick == 9) begin
                // slow counter part-fills a block, a fast one closes it:
                // the block average can come out below one microsecond
                set_counter(1'b1, 1'($urandom_range(0, 1)), 1'b1,
                            HZ_W'($urandom_range(0, 999)));
                play_run($urandom_range(8, 30), 0, 32'd1, 32'd3);
                wait_results();
                hz = HZ_W'($urandom_range(1073741823, 500000000));
                set_counter(1'b0, 1'b0, 1'b1, hz);
                play_run($urandom_range(20, 40), 0, hz / 1000000 + 1, hz / 1000000 + 3);
            end else begin
                case ($urandom_range(0, 7))
                    0: hz = 30'd1000000;
                    1: hz = 30'd1000000000;
                    2: hz = '1;
                    3: hz = HZ_W'($urandom_range(0, 999999));
                    default: hz = HZ_W'($urandom_range(1000000000, 1000000));
                endcase
                set_counter(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 3) != 0), hz);
                if ($urandom_range(0, 1)) begin
                    // musical tempo at the current counter rate, about 1% jitter
                    bpm     = $urandom_range(20, 300);
                    nominal = (64'(cur_hz) * 64'd60) / (bpm * 64'd24);
                    if (nominal == 0)
                        nominal = 1;
                    hi = STAMP_W'(nominal + nominal / 100);
                    lo = STAMP_W'(nominal - nominal / 100);
                end else begin
                    shift = $urandom_range(0, 31);
                    hi    = 32'd1 << shift;
                    lo    = (shift == 0) ? 32'd1 : hi >> 1;
                end
                play_run($urandom_range(10, 60),
                         (pick < 5) ? 0 : ((pick < 7) ? 40 : ((pick < 8) ? 6 : 1)), lo, hi);
            end
        end

        wait_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.pending() != 0)
            tracker.report_error($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/mctm_pkg.sv
design/midi_clock_tempo_meter_core.sv
test/tb.sv
